// File: src/gwd_pkg.sv
// Types, constants and helper functions shared by the weekday-from-date pipeline.
// No dependencies; imported by the interfaces and by every module of the block.
package gwd_pkg;

	// Field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int WDAY_W  = 3;
	localparam int DAYS_W  = 23;

	// Pipeline depth
	localparam int STAGES = 5;

	// Largest year the input field can carry
	localparam int YEAR_LIMIT = 2 ** YEAR_W - 1;

	// Reference date: 13 January 2023, a Friday
	localparam int REF_DAY     = 13;
	localparam int REF_YEAR    = 2023;
	localparam int REF_WEEKDAY = 5;

	// Days from 1 January of year 0 to the reference date, counted from day 0
	localparam int REF_COUNT = REF_YEAR * 365 + (REF_YEAR + 3) / 4
		- (REF_YEAR + 99) / 100 + (REF_YEAR + 399) / 400 + REF_DAY;

	// Weekday offset applied to the non-negative absolute count
	localparam int WD_OFF = (REF_WEEKDAY + 7 - REF_COUNT % 7) % 7;

	// Reciprocal multipliers for ceiling divisions by 100 and 400 on 15-bit values
	localparam int DIV100_MUL = 20972;
	localparam int DIV100_SH  = 21;
	localparam int DIV400_MUL = 20972;
	localparam int DIV400_SH  = 23;

	typedef logic [DAY_W-1:0]          day_t;
	typedef logic [MONTH_W-1:0]        month_t;
	typedef logic [YEAR_W-1:0]         year_t;
	typedef logic [WDAY_W-1:0]         weekday_t;
	typedef logic signed [DAYS_W-1:0]  days_t;
	typedef logic [DAYS_W-1:0]         count_t;
	typedef logic [8:0]                prefix_t;
	typedef logic [7:0]                cent_t;
	typedef logic [5:0]                quad_cent_t;
	typedef logic [YEAR_W-2:0]         quad_t;

	// Per-stage load enables and valid bits
	typedef struct packed {
		logic [STAGES-1:0] en;
		logic [STAGES-1:0] vld;
	} ctrl_t;

	// Days before the first of the month in a common year; months past 12 give the year
	function automatic prefix_t month_prefix(input month_t m);
		prefix_t p;
		unique case (m)
			4'd0:    p = 9'd0;
			4'd1:    p = 9'd0;
			4'd2:    p = 9'd31;
			4'd3:    p = 9'd59;
			4'd4:    p = 9'd90;
			4'd5:    p = 9'd120;
			4'd6:    p = 9'd151;
			4'd7:    p = 9'd181;
			4'd8:    p = 9'd212;
			4'd9:    p = 9'd243;
			4'd10:   p = 9'd273;
			4'd11:   p = 9'd304;
			4'd12:   p = 9'd334;
			default: p = 9'd365;
		endcase
		return p;
	endfunction

	// Remainder by 7 through octal digit folding (8 is 1 modulo 7)
	function automatic weekday_t mod7(input logic [23:0] x);
		logic [5:0] s;
		logic [3:0] t;
		weekday_t   r;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 6'(x[3*i +: 3]);
		end
		t = 4'(s[5:3]) + 4'(s[2:0]);
		if (t >= 4'd14) begin
			r = 3'(t - 4'd14);
		end else if (t >= 4'd7) begin
			r = 3'(t - 4'd7);
		end else begin
			r = 3'(t);
		end
		return r;
	endfunction

endpackage

// File: src/gwd_if.sv
// Valid/ready channel interfaces for date transactions and result transactions.
// Depends on gwd_pkg for the payload types.
interface gwd_date_if;
	import gwd_pkg::*;
	logic   valid;
	logic   ready;
	day_t   day_of_month;
	month_t month_number;
	year_t  year_number;

	modport source (output valid, output day_of_month, output month_number,
		output year_number, input ready);
	modport sink (input valid, input day_of_month, input month_number,
		input year_number, output ready);
endinterface

interface gwd_result_if;
	import gwd_pkg::*;
	logic     valid;
	logic     ready;
	weekday_t weekday;
	days_t    days_from_reference;

	modport source (output valid, output weekday, output days_from_reference,
		input ready);
	modport sink (input valid, input weekday, input days_from_reference,
		output ready);
endinterface

// File: src/gwd_ctrl.sv
// Valid bits and per-stage load enables of the five-stage pipeline.
// Depends on gwd_pkg for the control struct.
module gwd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_ready,
	output logic            in_ready,
	output gwd_pkg::ctrl_t  ctrl
);
	import gwd_pkg::*;

	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] en;

	// A stage loads when it is empty or when the stage after it moves on
	always_comb begin
		en[STAGES-1] = out_ready || !vld_q[STAGES-1];
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// Advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign ctrl.en  = en;
	assign ctrl.vld = vld_q;

	// An accepted transaction occupies the first stage next cycle
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transaction missing from first stage");

	// A blocked stage keeps its transaction
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[STAGES-2] && !en[STAGES-1] |=> vld_q[STAGES-2])
		else $error("stalled transaction dropped");

	// With the sink ready the whole pipeline moves
	a_ready_moves_all: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> (&en))
		else $error("pipeline stalled while sink ready");

endmodule

// File: src/gwd_year_div.sv
// Stages 1 and 2: year clamp, then leap-count quotients by reciprocal multiply.
// Depends on gwd_pkg for types and division constants.
module gwd_year_div #(
	parameter int YEAR_MAX = 9999
) (
	input  logic                clk,
	input  gwd_pkg::ctrl_t      ctrl,
	input  gwd_pkg::day_t       day_in,
	input  gwd_pkg::month_t     month_in,
	input  gwd_pkg::year_t      year_in,
	output gwd_pkg::day_t       day_s2,
	output gwd_pkg::month_t     month_s2,
	output gwd_pkg::year_t      year_s2,
	output gwd_pkg::quad_t      c4_s2,
	output gwd_pkg::cent_t      c100_s2,
	output gwd_pkg::quad_cent_t c400_s2
);
	import gwd_pkg::*;

	localparam int    YEAR_TOP   = (YEAR_MAX > YEAR_LIMIT) ? YEAR_LIMIT : YEAR_MAX;
	localparam year_t YEAR_CLAMP = year_t'(YEAR_TOP);

	day_t   day_s1;
	month_t month_s1;
	year_t  year_s1;

	logic [YEAR_W:0] y3;
	logic [YEAR_W:0] y99;
	logic [YEAR_W:0] y399;
	logic [29:0]     p100;
	logic [29:0]     p400;

	// Stage 1: capture and saturate the year
	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			day_s1   <= day_in;
			month_s1 <= month_in;
			year_s1  <= (year_in > YEAR_CLAMP) ? YEAR_CLAMP : year_in;
		end
	end

	// Ceilings of year over 4, 100 and 400
	always_comb begin
		y3   = (YEAR_W+1)'(year_s1) + (YEAR_W+1)'(3);
		y99  = (YEAR_W+1)'(year_s1) + (YEAR_W+1)'(99);
		y399 = (YEAR_W+1)'(year_s1) + (YEAR_W+1)'(399);
		p100 = 30'(y99) * 30'(DIV100_MUL);
		p400 = 30'(y399) * 30'(DIV400_MUL);
	end

	// Stage 2: hold quotients
	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			day_s2   <= day_s1;
			month_s2 <= month_s1;
			year_s2  <= year_s1;
			c4_s2    <= y3[YEAR_W:2];
			c100_s2  <= p100[DIV100_SH +: 8];
			c400_s2  <= p400[DIV400_SH +: 6];
		end
	end

endmodule

// File: src/gwd_day_sum.sv
// Stages 3 and 4: leap test, year days, month prefix, and the absolute day count.
// Depends on gwd_pkg for types and the month prefix function.
module gwd_day_sum (
	input  logic                clk,
	input  gwd_pkg::ctrl_t      ctrl,
	input  gwd_pkg::day_t       day_s2,
	input  gwd_pkg::month_t     month_s2,
	input  gwd_pkg::year_t      year_s2,
	input  gwd_pkg::quad_t      c4_s2,
	input  gwd_pkg::cent_t      c100_s2,
	input  gwd_pkg::quad_cent_t c400_s2,
	output gwd_pkg::count_t     count_s4
);
	import gwd_pkg::*;

	count_t  yd_s3;
	quad_t   leaps_s3;
	prefix_t prefix_s3;
	day_t    day_s3;

	logic    cent;
	logic    quad_cent;
	logic    leap;
	prefix_t prefix;

	// Leap rule from the ceiling quotients: exact multiples mark centuries
	always_comb begin
		cent      = (15'(c100_s2) * 15'(100)) == 15'(year_s2);
		quad_cent = (15'(c400_s2) * 15'(400)) == 15'(year_s2);
		leap      = (year_s2[1:0] == 2'b00) && (!cent || quad_cent);
		prefix    = month_prefix(month_s2);
		if (leap && month_s2 > 4'd2) begin
			prefix = prefix + 9'd1;
		end
	end

	// Stage 3: year days, leap count, month prefix
	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			yd_s3     <= DAYS_W'(year_s2) * DAYS_W'(365);
			leaps_s3  <= c4_s2 - quad_t'(c100_s2) + quad_t'(c400_s2);
			prefix_s3 <= prefix;
			day_s3    <= day_s2;
		end
	end

	// Stage 4: absolute count from day 0 of year 0
	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			count_s4 <= yd_s3 + DAYS_W'(leaps_s3) + DAYS_W'(prefix_s3) + DAYS_W'(day_s3);
		end
	end

endmodule

// File: src/gwd_wd_out.sv
// Stage 5: offset to the reference date and weekday by remainder of 7.
// Depends on gwd_pkg for types, reference constants and mod7.
module gwd_wd_out (
	input  logic            clk,
	input  gwd_pkg::ctrl_t  ctrl,
	input  gwd_pkg::count_t count_s4,
	output gwd_pkg::weekday_t weekday_s5,
	output gwd_pkg::days_t    days_s5
);
	import gwd_pkg::*;

	// Stage 5: signed distance and weekday, held for the sink
	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			days_s5    <= days_t'(count_s4 - DAYS_W'(REF_COUNT));
			weekday_s5 <= mod7(24'(count_s4) + 24'(WD_OFF));
		end
	end

endmodule

// File: src/gregorian_weekday_from_date_core.sv
// Gregorian weekday and signed day count from 13 January 2023.
// Each date transaction passes through five registered stages on its way to the result transaction.
// Throughput: one transaction per cycle; a stalled sink backs up stage by stage.
// Reset clears the valid bits of all five stages; no result is shown after reset.
// Depends on gwd_pkg, gwd_if, gwd_ctrl, gwd_year_div, gwd_day_sum and gwd_wd_out.
module gregorian_weekday_from_date_core #(
	parameter int YEAR_MAX = 9999
) (
	input  logic         clk,
	input  logic         arst_n,
	gwd_date_if.sink     date,
	gwd_result_if.source result
);
	import gwd_pkg::*;

	ctrl_t      ctrl;
	day_t       day_s2;
	month_t     month_s2;
	year_t      year_s2;
	quad_t      c4_s2;
	cent_t      c100_s2;
	quad_cent_t c400_s2;
	count_t     count_s4;
	weekday_t   weekday_s5;
	days_t      days_s5;

	// Pipeline control
	gwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (date.valid),
		.out_ready (result.ready),
		.in_ready  (date.ready),
		.ctrl      (ctrl)
	);

	// Year clamp and leap quotients
	gwd_year_div #(
		.YEAR_MAX (YEAR_MAX)
	) u_year_div (
		.clk      (clk),
		.ctrl     (ctrl),
		.day_in   (date.day_of_month),
		.month_in (date.month_number),
		.year_in  (date.year_number),
		.day_s2   (day_s2),
		.month_s2 (month_s2),
		.year_s2  (year_s2),
		.c4_s2    (c4_s2),
		.c100_s2  (c100_s2),
		.c400_s2  (c400_s2)
	);

	// Absolute day count
	gwd_day_sum u_day_sum (
		.clk      (clk),
		.ctrl     (ctrl),
		.day_s2   (day_s2),
		.month_s2 (month_s2),
		.year_s2  (year_s2),
		.c4_s2    (c4_s2),
		.c100_s2  (c100_s2),
		.c400_s2  (c400_s2),
		.count_s4 (count_s4)
	);

	// Reference offset and weekday
	gwd_wd_out u_wd_out (
		.clk        (clk),
		.ctrl       (ctrl),
		.count_s4   (count_s4),
		.weekday_s5 (weekday_s5),
		.days_s5    (days_s5)
	);

	assign result.valid               = ctrl.vld[STAGES-1];
	assign result.weekday             = weekday_s5;
	assign result.days_from_reference = days_s5;

endmodule

// File: sim/gregorian_weekday_from_date_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_weekday_from_date_core: directed and random dates.
// Depends on gwd_pkg, gwd_if and the core; predicts weekday and day count independently.
module gregorian_weekday_from_date_core_tb;
	import gwd_pkg::*;

	localparam int TB_YEAR_MAX = 9999;
	localparam int CLK_HALF    = 2;
	localparam int TAIL_CYCLES = 4 * STAGES;
	localparam longint RUN_LIMIT_NS = 2_000_000;

	// Days before the first of each month in a common year; months past 12 give the year
	localparam int COMMON_DAYS_BEFORE [16] = '{
		0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
	};

	typedef struct {
		day_t   day;
		month_t month;
		year_t  year;
	} date_t;

	typedef struct {
		weekday_t wd;
		days_t    days;
	} weekday_count_t;

	logic clk;
	logic arst_n;

	gwd_date_if   date_ch ();
	gwd_result_if result_ch ();

	gregorian_weekday_from_date_core #(
		.YEAR_MAX (TB_YEAR_MAX)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.date   (date_ch),
		.result (result_ch)
	);

	date_t          dates_to_send [$];
	weekday_count_t due_results [$];
	int             sender_idle_pct;
	int             sink_idle_pct;
	int             fail_count;
	int             dates_accepted;
	int             results_checked;

	// Days from 1 January of year 0 to 1 January of year y
	function automatic longint days_to_year_start(input longint y);
		return y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// Predict weekday and signed day count from the reference date
	function automatic weekday_count_t weekday_of_date(input date_t dt);
		weekday_count_t r;
		longint y;
		longint before_month;
		longint count;
		bit     leap;
		y = longint'(dt.year);
		if (y > TB_YEAR_MAX) begin
			y = TB_YEAR_MAX;
		end
		leap = (y % 100 == 0) ? (y % 400 == 0) : (y % 4 == 0);
		before_month = COMMON_DAYS_BEFORE[dt.month];
		if (dt.month > 4'd2 && leap) begin
			before_month += 1;
		end
		count = days_to_year_start(y) - days_to_year_start(REF_YEAR)
			+ before_month + longint'(dt.day) - REF_DAY;
		r.wd   = weekday_t'(((count % 7) + 7 + REF_WEEKDAY) % 7);
		r.days = days_t'(count[DAYS_W-1:0]);
		return r;
	endfunction

	task automatic queue_date(input int d, input int m, input int y);
		date_t dt;
		dt.day   = day_t'(d);
		dt.month = month_t'(m);
		dt.year  = year_t'(y);
		dates_to_send.push_back(dt);
	endtask

	// Mostly in-range fields (day 1 to 31, month 1 to 12, year 1 to the maximum), the rest raw field noise
	task automatic queue_random_dates(input int n);
		date_t dt;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 80) begin
				dt.day   = day_t'($urandom_range(31, 1));
				dt.month = month_t'($urandom_range(12, 1));
				dt.year  = year_t'($urandom_range(TB_YEAR_MAX, 1));
			end else begin
				dt.day   = day_t'($urandom);
				dt.month = month_t'($urandom);
				dt.year  = year_t'($urandom);
			end
			dates_to_send.push_back(dt);
		end
	endtask

	// Hold until every queued date is accepted and every result has returned
	task automatic wait_drained();
		while (dates_to_send.size() != 0 || date_ch.valid || due_results.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Clock, initial input values and reset
	initial begin
		clk                        = 1'b0;
		arst_n                     = 1'b0;
		date_ch.valid              = 1'b0;
		date_ch.day_of_month       = '0;
		date_ch.month_number       = '0;
		date_ch.year_number        = '0;
		result_ch.ready            = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Drive date transactions from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_ch.valid        <= 1'b0;
			date_ch.day_of_month <= '0;
			date_ch.month_number <= '0;
			date_ch.year_number  <= '0;
		end else if (!date_ch.valid || date_ch.ready) begin
			if (dates_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				date_t dt;
				dt = dates_to_send.pop_front();
				date_ch.valid        <= 1'b1;
				date_ch.day_of_month <= dt.day;
				date_ch.month_number <= dt.month;
				date_ch.year_number  <= dt.year;
			end else begin
				date_ch.valid <= 1'b0;
			end
		end
	end

	// Stall the result channel at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Predict on every accepted date transaction
	always @(posedge clk) begin
		if (arst_n && date_ch.valid && date_ch.ready) begin
			date_t dt;
			dt.day   = date_ch.day_of_month;
			dt.month = date_ch.month_number;
			dt.year  = date_ch.year_number;
			due_results.push_back(weekday_of_date(dt));
			dates_accepted++;
		end
	end

	// Compare every accepted result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (due_results.size() == 0) begin
				$error("result with no date outstanding: weekday %0d, days %0d",
					result_ch.weekday, result_ch.days_from_reference);
				fail_count++;
			end else begin
				weekday_count_t exp_r;
				exp_r = due_results.pop_front();
				results_checked++;
				if (result_ch.weekday !== exp_r.wd) begin
					$error("weekday mismatch: expected %0d, actual %0d",
						exp_r.wd, result_ch.weekday);
					fail_count++;
				end
				if (result_ch.days_from_reference !== exp_r.days) begin
					$error("days_from_reference mismatch: expected %0d, actual %0d",
						exp_r.days, result_ch.days_from_reference);
					fail_count++;
				end
			end
		end
	end

	// Stimulus phases
	initial begin
		fail_count      = 0;
		dates_accepted  = 0;
		results_checked = 0;
		sender_idle_pct = 37;
		sink_idle_pct   = 47;
		@(posedge arst_n);
		@(negedge clk);

		// Reference date, neighbours and field extremes
		queue_date(13, 1, 2023);
		queue_date(12, 1, 2023);
		queue_date(14, 1, 2023);
		queue_date(31, 12, 2022);
		queue_date(1, 1, 1);
		queue_date(0, 1, 1);
		queue_date(31, 12, 9999);
		queue_date(1, 12, 8192);
		// Year zero, month zero and day zero together, then month zero alone
		queue_date(0, 0, 0);
		queue_date(1, 0, 2023);
		// Years past the maximum saturate; the maximum year itself with month 15 for comparison
		queue_date(1, 1, 10000);
		queue_date(31, 15, 16383);
		queue_date(31, 15, 9999);
		// Leap handling and days beyond the month length
		queue_date(29, 2, 2024);
		queue_date(29, 2, 2023);
		queue_date(31, 2, 2023);
		queue_date(31, 2, 2024);
		queue_date(0, 3, 2023);
		queue_date(1, 3, 1900);
		queue_date(1, 3, 2000);
		queue_date(1, 3, 2100);
		// Months past December count from the next year
		queue_date(1, 13, 2023);
		queue_date(1, 14, 2024);
		queue_random_dates(180);
		wait_drained();

		sender_idle_pct = 47;
		sink_idle_pct   = 37;
		queue_random_dates(200);
		wait_drained();

		sender_idle_pct = 0;
		sink_idle_pct   = 0;
		queue_random_dates(200);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d dates (directed edge cases, then random under three stall patterns).",
			dates_accepted);
		$display("Checked %0d results, %0d field mismatches.", results_checked, fail_count);
		if (fail_count == 0 && due_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#(RUN_LIMIT_NS);
		$display("Run timed out with %0d results outstanding.", due_results.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: gregorian_weekday_from_date_core.f
src/gwd_pkg.sv
src/gwd_if.sv
src/gwd_ctrl.sv
src/gwd_year_div.sv
src/gwd_day_sum.sv
src/gwd_wd_out.sv
src/gregorian_weekday_from_date_core.sv
sim/gregorian_weekday_from_date_core_tb.sv
